[design/mbps_pkg.sv]
// Shared types and constants for the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int PAT_BYTES   = 32;
    localparam int PAT_IDX_W   = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int LEN_FIELD_W = 6;
    localparam int FIELD_W     = 32;

    localparam logic [FIELD_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT0     = 3'd0,
        CFG_PAT1     = 3'd1,
        CFG_PAT2     = 3'd2,
        CFG_PAT3     = 3'd3,
        CFG_CARE     = 3'd4,
        CFG_LENGTH   = 3'd5,
        CFG_FIND_ALL = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        RES_MATCH   = 1'b0,
        RES_SUMMARY = 1'b1
    } t_res_kind;

    typedef struct packed {
        t_res_kind          kind;
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] total;
        logic               last_res;
    } t_result;

    typedef struct packed {
        logic    first_vld;
        logic    second_vld;
        t_result first;
        t_result second;
    } t_push;

endpackage

`default_nettype wire

[design/mbps_compare.sv]
// Masked compare of the shifted byte window against the pattern.
`default_nettype none

module mbps_compare #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  wire logic [PATTERN_MAX-1:0][7:0]           i_window,
    input  wire logic [mbps_pkg::PAT_BYTES*8-1:0]      i_pattern,
    input  wire logic [mbps_pkg::PAT_BYTES-1:0]        i_care,
    input  wire logic [LEN_W-1:0]                      i_len,
    output logic                                       o_match
);

    logic [PATTERN_MAX-1:0] byte_ok;

    always_comb begin
        logic [LEN_W-1:0]               k;
        logic [mbps_pkg::PAT_IDX_W-1:0] k5;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            k  = i_len - LEN_W'(1) - LEN_W'(j);
            k5 = mbps_pkg::PAT_IDX_W'(k);
            if (LEN_W'(j) < i_len && i_care[k5]) begin
                byte_ok[j] = (i_window[j] == i_pattern[{k5, 3'b000} +: 8]);
            end else begin
                byte_ok[j] = 1'b1;
            end
        end
    end

    assign o_match = &byte_ok;

endmodule

`default_nettype wire

[design/mbps_core.sv]
// Input register, window and region state, and result generation.
`default_nettype none

module mbps_core #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic [7:0]                             i_data_byte,
    input  wire logic                                   i_last_byte,
    input  wire logic [mbps_pkg::PAT_BYTES*8-1:0]       i_pattern,
    input  wire logic [mbps_pkg::PAT_BYTES-1:0]         i_care,
    input  wire logic [mbps_pkg::LEN_FIELD_W-1:0]       i_length,
    input  wire logic                                   i_find_all,
    input  wire logic                                   i_room,
    output mbps_pkg::t_push                             o_push
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int OW    = (OFFSET_BITS > mbps_pkg::FIELD_W) ? OFFSET_BITS : mbps_pkg::FIELD_W;

    logic                           r_in_valid;
    logic [7:0]                     r_in_byte;
    logic                           r_in_last;
    logic [PATTERN_MAX-1:0][7:0]    r_win;
    logic [LEN_W-1:0]               r_fill;
    logic [OFFSET_BITS-1:0]         r_pos;
    logic [mbps_pkg::FIELD_W-1:0]   r_total;
    logic                           r_stopped;

    logic [PATTERN_MAX-1:0][7:0]    n_win;
    logic [LEN_W-1:0]               n_fill;
    logic [mbps_pkg::FIELD_W-1:0]   n_total;
    logic [LEN_W-1:0]               eff_len;
    logic                           win_match;
    logic                           hit;
    logic                           advance;
    logic [OFFSET_BITS-1:0]         start;
    logic [OW-1:0]                  start_w;
    mbps_pkg::t_result              res_match;
    mbps_pkg::t_result              res_sum;

    assign advance    = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || i_room;

    always_comb begin
        if (i_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (i_length > mbps_pkg::LEN_FIELD_W'(PATTERN_MAX)) begin
            eff_len = LEN_W'(PATTERN_MAX);
        end else begin
            eff_len = LEN_W'(i_length);
        end
    end

    always_comb begin
        n_win[0] = r_in_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    assign n_fill = (r_fill < LEN_W'(PATTERN_MAX)) ? r_fill + LEN_W'(1) : r_fill;

    mbps_compare #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_compare (
        .i_window  (n_win),
        .i_pattern (i_pattern),
        .i_care    (i_care),
        .i_len     (eff_len),
        .o_match   (win_match)
    );

    assign hit     = !r_stopped && (n_fill >= eff_len) && win_match;
    assign n_total = (hit && r_total != mbps_pkg::TOTAL_MAX) ? r_total + 1'b1 : r_total;
    assign start   = r_pos - OFFSET_BITS'(eff_len) + OFFSET_BITS'(1);
    assign start_w = OW'(start);

    always_comb begin
        res_match.kind     = mbps_pkg::RES_MATCH;
        res_match.offset   = start_w[mbps_pkg::FIELD_W-1:0];
        res_match.total    = n_total;
        res_match.last_res = !r_in_last;
        res_sum.kind       = mbps_pkg::RES_SUMMARY;
        res_sum.offset     = '0;
        res_sum.total      = n_total;
        res_sum.last_res   = 1'b1;

        o_push.first_vld  = advance && (hit || r_in_last);
        o_push.second_vld = advance && hit && r_in_last;
        o_push.first      = hit ? res_match : res_sum;
        o_push.second     = res_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= '0;
            r_fill    <= '0;
            r_pos     <= '0;
            r_total   <= '0;
            r_stopped <= 1'b0;
        end else if (advance) begin
            if (r_in_last) begin
                r_win     <= '0;
                r_fill    <= '0;
                r_pos     <= '0;
                r_total   <= '0;
                r_stopped <= 1'b0;
            end else begin
                r_win   <= n_win;
                r_fill  <= n_fill;
                r_pos   <= r_pos + OFFSET_BITS'(1);
                r_total <= n_total;
                if (hit && !i_find_all) begin
                    r_stopped <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[design/mbps_out_fifo.sv]
// Four-entry result queue, up to two writes and one read per cycle.
`default_nettype none

module mbps_out_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mbps_pkg::t_push i_push,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_ready,
    output mbps_pkg::t_result   o_result
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbps_pkg::t_result      r_mem [DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;

    logic [PTR_W-1:0]       wr_ptr2;
    logic [CNT_W-1:0]       n_pushes;
    logic                   pop;

    assign o_room   = r_count <= CNT_W'(DEPTH - 2);
    assign o_valid  = r_count != '0;
    assign o_result = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;
    assign wr_ptr2  = r_wr_ptr + PTR_W'(1);
    assign n_pushes = CNT_W'(i_push.first_vld) + CNT_W'(i_push.second_vld);

    always_ff @(posedge i_clk) begin
        if (i_push.first_vld) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.second_vld) begin
            r_mem[wr_ptr2] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(n_pushes);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + n_pushes - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

[design/masked_byte_pattern_scanner_top.sv]
// Top level of the masked byte pattern scanner.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  in       | i_in_valid / o_in_ready    | i_data_byte, i_last_byte
//  out      | o_out_valid / i_out_ready  | o_result_kind, o_match_offset,
//           |                            | o_match_total, o_final_result
//  cfg      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One byte per cycle while the result queue has room; a byte's results pass through the input register and the queue.
// A byte giving both a match and a summary yields two output words, the match first.
// The result queue holds four entries; a byte waits in the input register while fewer than two are free.
// Reset is synchronous and clears region state and the queue.
`default_nettype none

module masked_byte_pattern_scanner_top #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [7:0]                            i_data_byte,
    input  wire logic                                  i_last_byte,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic                                       o_result_kind,
    output logic [mbps_pkg::FIELD_W-1:0]               o_match_offset,
    output logic [mbps_pkg::FIELD_W-1:0]               o_match_total,
    output logic                                       o_final_result,
    input  wire logic                                  i_cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [mbps_pkg::CFG_DATA_W-1:0]  r_pat0;
    logic [mbps_pkg::CFG_DATA_W-1:0]  r_pat1;
    logic [mbps_pkg::CFG_DATA_W-1:0]  r_pat2;
    logic [mbps_pkg::CFG_DATA_W-1:0]  r_pat3;
    logic [mbps_pkg::PAT_BYTES-1:0]   r_care;
    logic [mbps_pkg::LEN_FIELD_W-1:0] r_length;
    logic                             r_find_all;

    mbps_pkg::t_push                  push;
    mbps_pkg::t_result                result;
    logic                             room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat0     <= '0;
            r_pat1     <= '0;
            r_pat2     <= '0;
            r_pat3     <= '0;
            r_care     <= '1;
            r_length   <= mbps_pkg::LEN_FIELD_W'(1);
            r_find_all <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbps_pkg::CFG_PAT0:     r_pat0 <= i_cfg_data;
                mbps_pkg::CFG_PAT1:     r_pat1 <= i_cfg_data;
                mbps_pkg::CFG_PAT2:     r_pat2 <= i_cfg_data;
                mbps_pkg::CFG_PAT3:     r_pat3 <= i_cfg_data;
                mbps_pkg::CFG_CARE:     r_care <= i_cfg_data[mbps_pkg::PAT_BYTES-1:0];
                mbps_pkg::CFG_LENGTH:   r_length <= i_cfg_data[mbps_pkg::LEN_FIELD_W-1:0];
                mbps_pkg::CFG_FIND_ALL: r_find_all <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mbps_core #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_pattern   ({r_pat3, r_pat2, r_pat1, r_pat0}),
        .i_care      (r_care),
        .i_length    (r_length),
        .i_find_all  (r_find_all),
        .i_room      (room),
        .o_push      (push)
    );

    mbps_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    assign o_result_kind  = result.kind;
    assign o_match_offset = result.offset;
    assign o_match_total  = result.total;
    assign o_final_result = result.last_res;

endmodule

`default_nettype wire

[design/mbps_checker.sv]
// Port-level checks for the scanner top, bound to it.
`default_nettype none

module mbps_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic                        o_result_kind,
    input  wire logic [mbps_pkg::FIELD_W-1:0] o_match_offset,
    input  wire logic [mbps_pkg::FIELD_W-1:0] o_match_total,
    input  wire logic                        o_final_result
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_summary_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == mbps_pkg::RES_SUMMARY
            |-> o_match_offset == '0 && o_final_result)
        else $error("summary word malformed");

    a_match_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind == mbps_pkg::RES_MATCH |-> o_match_total != '0)
        else $error("match word with zero total");

    a_match_then_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_result_kind == mbps_pkg::RES_MATCH
            && !o_final_result
            |=> o_out_valid && o_result_kind == mbps_pkg::RES_SUMMARY)
        else $error("match on last byte not followed by summary");

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_kind  (o_result_kind),
    .o_match_offset (o_match_offset),
    .o_match_total  (o_match_total),
    .o_final_result (o_final_result)
);

`default_nettype wire
